>>> hw/rtl/gpp_pkg.sv
// Shared types, codes and constants of the 32-pin GPIO port.
// No dependencies; every module of the port imports this package.
package gpp_pkg;

    localparam int PIN_COUNT   = 32;
    localparam int PIN_SLOTS   = 32;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 136;

    localparam logic [31:0] PIN_MASK  = 32'hFFFF_FFFF >> (32 - PIN_COUNT);
    localparam logic [31:0] CNF_RESET = 32'h0000_0002;

    // operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_EVENT = 2'd2;

    // register select codes
    localparam logic [3:0] REG_OUT    = 4'd0;
    localparam logic [3:0] REG_OUTSET = 4'd1;
    localparam logic [3:0] REG_OUTCLR = 4'd2;
    localparam logic [3:0] REG_IN     = 4'd3;
    localparam logic [3:0] REG_DIR    = 4'd4;
    localparam logic [3:0] REG_DIRSET = 4'd5;
    localparam logic [3:0] REG_DIRCLR = 4'd6;
    localparam logic [3:0] REG_CNF    = 4'd7;

    // sense codes in config bits 17:16
    localparam logic [1:0] SENSE_HIGH = 2'd2;
    localparam logic [1:0] SENSE_LOW  = 2'd3;

    // pull codes in config bits 3:2
    localparam logic [1:0] PULL_DOWN = 2'd1;
    localparam logic [1:0] PULL_UP   = 2'd3;

    typedef logic [PIN_SLOTS-1:0][31:0] cfg_array_t;

    typedef struct packed {
        logic        pin_level;
        logic        pin_driven;
        logic [4:0]  pin_index;
        logic [31:0] write_data;
        logic [4:0]  cnf_index;
        logic [3:0]  reg_select;
        logic [1:0]  operation;
    } gpp_item_t;

    typedef struct packed {
        logic        detect;
        logic [31:0] out_changed;
        logic [31:0] out_connected;
        logic [31:0] out_levels;
        logic        bad_access;
        logic [31:0] read_data;
    } gpp_result_t;

    typedef struct packed {
        logic [31:0] in_bits;
        logic [31:0] levels;
        logic [31:0] connected;
        logic        detect;
    } gpp_eval_t;

endpackage

>>> hw/rtl/gpio_port_pin_model.sv
// Top level of the 32-pin GPIO port: register file, pin state and result register.
// Depends on gpp_pkg, gpp_in_stage and gpp_pin_eval.
//
// Usage:
//   One slave stream carries bus reads, bus writes and external pin events;
//   one master stream returns exactly one result beat for every accepted beat.
//   A read returns OUT, IN, DIR or one pin config word; a write updates
//   OUT/DIR (plain, set, clear) or a config word; a pin event drives or
//   releases one pin. After every write or pin event all pins are evaluated
//   in parallel and the output levels, connected flags, changed mask and
//   sense detect are reported.
// Path: a beat accepted on the slave side passes the input register and
//   then the result register before it appears on the master side.
// Throughput: one beat per cycle when not stalled; the state is committed in the
//   same edge that loads the result register, so the next beat sees it at once.
// Stall: when the receiver holds tready low the result register holds and
//   the input register fills; the slave side keeps taking beats while either
//   register has room. State only changes when a beat advances.
// Reset: rst_n is asynchronous, active low. OUT, IN, DIR, the driven mask and
//   the last levels clear to zero; every pin config word reads 0x00000002.
module gpio_port_pin_model
    import gpp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [3:0] reg_select, [8:4] cnf_index, [40:9] write_data, [45:41] pin_index,
    // [46] pin_driven, [47] pin_level
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] read_data, [32] bad_access, [64:33] out_levels,
    // [96:65] out_connected, [128:97] out_changed, [129] detect, [135:130] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    gpp_item_t   item_in;
    gpp_item_t   item;
    logic        item_valid;
    logic        advance;

    logic [31:0] out_reg, out_next;
    logic [31:0] in_reg, in_pre;
    logic [31:0] driven_reg, driven_next;
    logic [31:0] dir_reg, dir_next;
    cfg_array_t  cfg_reg, cfg_next;
    logic [31:0] last_level_reg, last_conn_reg;

    logic        out_valid_reg;
    gpp_result_t res_reg, res_next;

    logic [31:0] rd;
    logic        bad;
    logic        do_eval;
    logic        cnf_ok;
    logic        pin_ok;
    logic [31:0] wd;
    gpp_eval_t   ev;

    assign item_in.operation  = s_axis_tuser;
    assign item_in.reg_select = s_axis_tdata[3:0];
    assign item_in.cnf_index  = s_axis_tdata[8:4];
    assign item_in.write_data = s_axis_tdata[40:9];
    assign item_in.pin_index  = s_axis_tdata[45:41];
    assign item_in.pin_driven = s_axis_tdata[46];
    assign item_in.pin_level  = s_axis_tdata[47];

    // advance the held beat whenever the result register is free or drains
    assign advance = item_valid && (!out_valid_reg || m_axis_tready);

    gpp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (item_in),
        .advance    (advance),
        .held_valid (item_valid),
        .held_item  (item)
    );

    assign cnf_ok = 6'(item.cnf_index) < 6'(PIN_COUNT);
    assign pin_ok = 6'(item.pin_index) < 6'(PIN_COUNT);
    assign wd     = item.write_data & PIN_MASK;

    // decode the beat into next register state and read data
    always_comb
    begin
        out_next    = out_reg;
        dir_next    = dir_reg;
        cfg_next    = cfg_reg;
        driven_next = driven_reg;
        in_pre      = in_reg;
        rd          = '0;
        bad         = 1'b0;
        do_eval     = 1'b0;
        unique case (item.operation)
            OP_READ:
            begin
                unique case (item.reg_select)
                    REG_OUT, REG_OUTSET, REG_OUTCLR: rd = out_reg;
                    REG_IN:                          rd = in_reg;
                    REG_DIR, REG_DIRSET, REG_DIRCLR: rd = dir_reg;
                    REG_CNF:
                    begin
                        if (cnf_ok)
                        begin
                            rd = cfg_reg[item.cnf_index];
                        end
                        else
                        begin
                            bad = 1'b1;
                        end
                    end
                    default: bad = 1'b1;
                endcase
            end
            OP_WRITE:
            begin
                do_eval = 1'b1;
                unique case (item.reg_select)
                    REG_OUT:    out_next = wd;
                    REG_OUTSET: out_next = out_reg | wd;
                    REG_OUTCLR: out_next = out_reg & ~wd;
                    REG_DIR:    dir_next = wd;
                    REG_DIRSET: dir_next = dir_reg | wd;
                    REG_DIRCLR: dir_next = dir_reg & ~wd;
                    REG_CNF:
                    begin
                        if (cnf_ok)
                        begin
                            cfg_next[item.cnf_index] = item.write_data;
                            dir_next[item.cnf_index] = item.write_data[0];
                        end
                        else
                        begin
                            bad = 1'b1;
                        end
                    end
                    default: bad = 1'b1;
                endcase
                // mirror DIR into bit 0 of every config word
                if ((item.reg_select == REG_DIR) || (item.reg_select == REG_DIRSET)
                    || (item.reg_select == REG_DIRCLR))
                begin
                    for (int i = 0; i < PIN_SLOTS; i++)
                    begin
                        if (i < PIN_COUNT)
                        begin
                            cfg_next[i][0] = dir_next[i];
                        end
                    end
                end
            end
            OP_EVENT:
            begin
                do_eval = 1'b1;
                if (pin_ok)
                begin
                    driven_next[item.pin_index] = item.pin_driven;
                    if (item.pin_driven)
                    begin
                        in_pre[item.pin_index] = item.pin_level;
                    end
                end
            end
            default:
            begin
                // idle beat: nothing changes
            end
        endcase
    end

    gpp_pin_eval u_pin_eval
    (
        .cfg         (cfg_next),
        .out_bits    (out_next),
        .driven_mask (driven_next),
        .in_pre      (in_pre),
        .eval_en     (do_eval),
        .result      (ev)
    );

    always_comb
    begin
        res_next.read_data  = rd;
        res_next.bad_access = bad;
        res_next.detect     = ev.detect;
        if (do_eval)
        begin
            res_next.out_levels    = ev.levels;
            res_next.out_connected = ev.connected;
            res_next.out_changed   = ((ev.levels ^ last_level_reg)
                                      | (ev.connected ^ last_conn_reg)) & PIN_MASK;
        end
        else
        begin
            res_next.out_levels    = last_level_reg;
            res_next.out_connected = last_conn_reg;
            res_next.out_changed   = '0;
        end
    end

    // commit port state together with the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg        <= '0;
            in_reg         <= '0;
            driven_reg     <= '0;
            dir_reg        <= '0;
            last_level_reg <= '0;
            last_conn_reg  <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < PIN_SLOTS; i++)
            begin
                cfg_reg[i] <= CNF_RESET;
            end
        end
        else if (advance)
        begin
            out_reg        <= out_next;
            in_reg         <= ev.in_bits;
            driven_reg     <= driven_next;
            dir_reg        <= dir_next;
            cfg_reg        <= cfg_next;
            last_level_reg <= res_next.out_levels;
            last_conn_reg  <= res_next.out_connected;
            out_valid_reg  <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, res_reg.detect, res_reg.out_changed,
                            res_reg.out_connected, res_reg.out_levels,
                            res_reg.bad_access, res_reg.read_data};

    // the shown levels and connected flags always match the committed state
    a_levels_track: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.out_levels == last_level_reg)
                          && (res_reg.out_connected == last_conn_reg))
        else $error("result levels differ from committed pin state");

    // a faulted access never returns data
    a_bad_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.bad_access) |-> (res_reg.read_data == '0))
        else $error("bad access returned nonzero read data");

    // a stalled result keeps the port state frozen
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> ($stable(dir_reg) && $stable(out_reg)
                                              && $stable(in_reg)))
        else $error("port state moved while the result stalled");

    // a held beat is not dropped while the result side is blocked
    a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !advance) |=> item_valid)
        else $error("held input beat lost");

    // bits beyond the pin count never reach the state
    a_pin_mask: assert property (@(posedge clk) disable iff (!rst_n)
        ((out_reg & ~PIN_MASK) == '0) && ((dir_reg & ~PIN_MASK) == '0)
        && ((in_reg & ~PIN_MASK) == '0))
        else $error("state bit set above the pin count");

endmodule

>>> hw/rtl/gpp_in_stage.sv
// Input register of the GPIO port: holds one accepted beat until it advances.
// Depends on gpp_pkg.
module gpp_in_stage
    import gpp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  gpp_item_t in_item,
    input  logic      advance,
    output logic      held_valid,
    output gpp_item_t held_item
);

    logic      valid_reg;
    logic      valid_next;
    gpp_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

>>> hw/rtl/gpp_pin_eval.sv
// Parallel evaluation of all pins: drive mode, pull, input buffer and sense.
// Depends on gpp_pkg.
module gpp_pin_eval
    import gpp_pkg::*;
(
    input  cfg_array_t  cfg,
    input  logic [31:0] out_bits,
    input  logic [31:0] driven_mask,
    input  logic [31:0] in_pre,
    input  logic        eval_en,
    output gpp_eval_t   result
);

    always_comb
    begin
        logic [31:0] in_bits;
        logic [31:0] sense_bits;
        logic [31:0] lv;
        logic [31:0] cn;
        logic [1:0]  pull;
        logic [2:0]  drive;
        logic [1:0]  sense;
        logic        has_pull;
        logic        pull_lvl;
        logic        o;
        logic        conn;

        in_bits = in_pre;
        lv      = '0;
        cn      = '0;
        for (int i = 0; i < PIN_SLOTS; i++)
        begin
            pull     = cfg[i][3:2];
            drive    = cfg[i][10:8];
            has_pull = (pull == PULL_DOWN) || (pull == PULL_UP);
            pull_lvl = (pull == PULL_UP);
            o        = out_bits[i];
            if (!drive[2])
            begin
                conn = 1'b1;
            end
            else if (!drive[1])
            begin
                conn = o;
            end
            else
            begin
                conn = !o;
            end
            conn = conn & cfg[i][0];
            if (i < PIN_COUNT)
            begin
                if (cfg[i][1])
                begin
                    if (has_pull)
                    begin
                        in_bits[i] = pull_lvl;
                    end
                end
                else if (!driven_mask[i])
                begin
                    if (has_pull && !conn)
                    begin
                        conn = 1'b1;
                        o    = pull_lvl;
                    end
                    if (conn)
                    begin
                        in_bits[i] = o;
                    end
                end
                lv[i] = o;
                cn[i] = conn;
            end
        end

        // reads and idle beats see the input register as it stands
        if (!eval_en)
        begin
            in_bits = in_pre;
        end

        sense_bits = '0;
        for (int i = 0; i < PIN_SLOTS; i++)
        begin
            sense = cfg[i][17:16];
            if (i < PIN_COUNT)
            begin
                sense_bits[i] = !cfg[i][1] && driven_mask[i]
                    && (((sense == SENSE_HIGH) && in_bits[i])
                        || ((sense == SENSE_LOW) && !in_bits[i]));
            end
        end

        result.in_bits   = in_bits;
        result.levels    = lv;
        result.connected = cn;
        result.detect    = |sense_bits;
    end

endmodule

>>> tb/tb.sv
// Self-checking testbench for the 32-pin GPIO port (gpio_port_pin_model).
// Depends on gpp_pkg for codes and beat layouts; a scoreboard class predicts
// every result beat and plain tasks drive the slave stream.
module tb;
    import gpp_pkg::*;

    // Codes that the package leaves unnamed
    localparam logic [1:0] OP_IDLE      = 2'd3;
    localparam logic [3:0] REG_UNMAP_LO = 4'd8;
    localparam logic [3:0] REG_UNMAP_HI = 4'd15;

    // Drive modes in config bits 10:8
    localparam logic [2:0] DRIVE_BOTH   = 3'd0;
    localparam logic [2:0] DRIVE_HIGH   = 3'd4;
    localparam logic [2:0] DRIVE_LOW    = 3'd6;
    localparam logic [1:0] PULL_NONE    = 2'd0;
    localparam logic [1:0] SENSE_NONE   = 2'd0;

    localparam int RANDOM_BEATS = 1300;
    localparam int STALL_LIMIT  = 2000;  // cycles without any accepted beat
    localparam int TAIL_CYCLES  = 8;     // two-register pipeline, with margin
    localparam int DRAIN_EVERY  = 250;

    // ------------------------------------------------------------------
    // Scoreboard: shadow copy of the port state, predicts one result beat
    // per accepted input beat and checks result beats in order.
    // ------------------------------------------------------------------
    class port_scoreboard;
        logic [31:0]  out_q;
        logic [31:0]  in_q;
        logic [31:0]  driven_q;
        logic [31:0]  dir_q;
        logic [31:0]  lvl_prev;
        logic [31:0]  conn_prev;
        logic [31:0]  cfg_q [PIN_SLOTS];
        gpp_result_t  expected_q [$];
        int           errors;
        int           checked;
        int           detect_seen;
        int           op_seen [4];

        function new();
            out_q = '0;
            in_q = '0;
            driven_q = '0;
            dir_q = '0;
            lvl_prev = '0;
            conn_prev = '0;
            for (int i = 0; i < PIN_SLOTS; i++)
                cfg_q[i] = CNF_RESET;
            errors = 0;
            checked = 0;
            detect_seen = 0;
            for (int i = 0; i < 4; i++)
                op_seen[i] = 0;
        endfunction

        // Resolve every pin from drive mode, pull and input buffer; return
        // the mask of pins whose level or connected flag moved.
        function logic [31:0] settle_pins();
            logic [31:0] lv;
            logic [31:0] cn;
            logic [31:0] c;
            logic        o;
            logic        k;
            logic        has_pull;
            logic        pull_lv;
            logic [31:0] moved;
            lv = '0;
            cn = '0;
            for (int i = 0; i < PIN_COUNT; i++)
            begin
                c = cfg_q[i];
                has_pull = (c[3:2] == PULL_DOWN) || (c[3:2] == PULL_UP);
                pull_lv = (c[3:2] == PULL_UP);
                o = out_q[i];
                if (c[10:8] < DRIVE_HIGH)
                    k = 1'b1;
                else if (c[10:8] < DRIVE_LOW)
                    k = o;
                else
                    k = ~o;
                k = k & c[0];
                if (c[1])
                begin
                    if (has_pull)
                        in_q[i] = pull_lv;
                end
                else if (!driven_q[i])
                begin
                    if (has_pull && !k)
                    begin
                        k = 1'b1;
                        o = pull_lv;
                    end
                    if (k)
                        in_q[i] = o;
                end
                lv[i] = o;
                cn[i] = k;
            end
            moved = ((lv ^ lvl_prev) | (cn ^ conn_prev)) & PIN_MASK;
            lvl_prev = lv;
            conn_prev = cn;
            return moved;
        endfunction

        function logic sense_any();
            logic hit;
            hit = 1'b0;
            for (int i = 0; i < PIN_COUNT; i++)
                if (!cfg_q[i][1] && driven_q[i] &&
                    ((cfg_q[i][17:16] == SENSE_HIGH && in_q[i]) ||
                     (cfg_q[i][17:16] == SENSE_LOW && !in_q[i])))
                    hit = 1'b1;
            return hit;
        endfunction

        function void copy_dir_to_cfg();
            for (int i = 0; i < PIN_COUNT; i++)
                cfg_q[i][0] = dir_q[i];
        endfunction

        // Note an accepted input beat: update the shadow state, queue the result.
        function void note_input(gpp_item_t it);
            gpp_result_t r;
            logic [31:0] wd;
            logic [31:0] moved;
            r = '0;
            wd = it.write_data & PIN_MASK;
            moved = '0;
            op_seen[it.operation]++;
            case (it.operation)
                OP_READ:
                    case (it.reg_select)
                        REG_OUT, REG_OUTSET, REG_OUTCLR: r.read_data = out_q;
                        REG_IN:                          r.read_data = in_q;
                        REG_DIR, REG_DIRSET, REG_DIRCLR: r.read_data = dir_q;
                        REG_CNF:
                            if (it.cnf_index < PIN_COUNT)
                                r.read_data = cfg_q[it.cnf_index];
                            else
                                r.bad_access = 1'b1;
                        default: r.bad_access = 1'b1;
                    endcase
                OP_WRITE:
                begin
                    case (it.reg_select)
                        REG_OUT:    out_q = wd;
                        REG_OUTSET: out_q = out_q | wd;
                        REG_OUTCLR: out_q = out_q & ~wd;
                        REG_DIR:
                        begin
                            dir_q = wd;
                            copy_dir_to_cfg();
                        end
                        REG_DIRSET:
                        begin
                            dir_q = dir_q | wd;
                            copy_dir_to_cfg();
                        end
                        REG_DIRCLR:
                        begin
                            dir_q = dir_q & ~wd;
                            copy_dir_to_cfg();
                        end
                        REG_CNF:
                            if (it.cnf_index < PIN_COUNT)
                            begin
                                cfg_q[it.cnf_index] = it.write_data;
                                dir_q[it.cnf_index] = it.write_data[0];
                            end
                            else
                                r.bad_access = 1'b1;
                        default: r.bad_access = 1'b1;
                    endcase
                    moved = settle_pins();
                end
                OP_EVENT:
                begin
                    if (it.pin_index < PIN_COUNT)
                    begin
                        driven_q[it.pin_index] = it.pin_driven;
                        if (it.pin_driven)
                            in_q[it.pin_index] = it.pin_level;
                    end
                    moved = settle_pins();
                end
                default: ;
            endcase
            r.out_levels = lvl_prev & PIN_MASK;
            r.out_connected = conn_prev & PIN_MASK;
            r.out_changed = moved;
            r.detect = sense_any();
            if (r.detect)
                detect_seen++;
            expected_q.push_back(r);
        endfunction

        task log_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("[%0t] mismatch in %s: got %h, want %h", $realtime, what, got, want);
        endtask

        // Check one accepted result beat against the oldest expectation.
        task check_result(logic [OUT_TDATA_W-1:0] beat);
            gpp_result_t got;
            gpp_result_t want;
            if (expected_q.size() == 0)
            begin
                log_mismatch("unexpected result beat", beat[31:0], '0);
                return;
            end
            got = beat[$bits(gpp_result_t)-1:0];
            want = expected_q.pop_front();
            checked++;
            if (got.read_data !== want.read_data)
                log_mismatch("read_data", got.read_data, want.read_data);
            if (got.bad_access !== want.bad_access)
                log_mismatch("bad_access", 32'(got.bad_access), 32'(want.bad_access));
            if (got.out_levels !== want.out_levels)
                log_mismatch("out_levels", got.out_levels, want.out_levels);
            if (got.out_connected !== want.out_connected)
                log_mismatch("out_connected", got.out_connected, want.out_connected);
            if (got.out_changed !== want.out_changed)
                log_mismatch("out_changed", got.out_changed, want.out_changed);
            if (got.detect !== want.detect)
                log_mismatch("detect", 32'(got.detect), 32'(want.detect));
            if (beat[OUT_TDATA_W-1:$bits(gpp_result_t)] !== '0)
                log_mismatch("tdata padding", 32'(beat[OUT_TDATA_W-1:$bits(gpp_result_t)]), '0);
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block
    // ------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [3:0] reg_select, [8:4] cnf_index, [40:9] write_data, [45:41] pin_index,
    // [46] pin_driven, [47] pin_level
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // [1:0] operation
    logic [1:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [31:0] read_data, [32] bad_access, [64:33] out_levels,
    // [96:65] out_connected, [128:97] out_changed, [129] detect, [135:130] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    port_scoreboard sb = new();
    bit             calm = 1'b0;    // hold both sides free of idling
    int             idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    gpio_port_pin_model dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Sample both handshakes at the edge; values seen here are the ones from
    // before the edge, since every driver updates through nonblocking writes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(gpp_item_t'({s_axis_tdata, s_axis_tuser}));
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // Receiver: drop tready at random, with a chance of 6 in 100, unless calm.
    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 6);

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Pack a pin config word from its fields.
    function automatic logic [31:0] cfg_word(logic dir, logic buf_off, logic [1:0] pull,
                                             logic [2:0] mode, logic [1:0] sense);
        return {14'b0, sense, 5'b0, mode, 4'b0, pull, buf_off, dir};
    endfunction

    // Present one beat and hold it until accepted; then maybe let the slave side idle.
    task automatic send_item(gpp_item_t it);
        {s_axis_tdata, s_axis_tuser} <= it;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (!calm && $urandom_range(99) < 6)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Directed beats: every field is given, unused ones included.
    task automatic send_fields(logic [1:0] op, logic [3:0] sel, logic [4:0] cidx,
                               logic [31:0] wd, logic [4:0] pidx, logic drv, logic lvl);
        gpp_item_t it;
        it.operation = op;
        it.reg_select = sel;
        it.cnf_index = cidx;
        it.write_data = wd;
        it.pin_index = pidx;
        it.pin_driven = drv;
        it.pin_level = lvl;
        send_item(it);
    endtask

    // Stop sending until every outstanding result beat has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        gpp_item_t   it;
        logic [63:0] raw;
        int          pick;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values and every read path, unmapped registers included
        send_fields(OP_READ, REG_OUT, 5'd0, '1, 5'd0, 1'b0, 1'b0);
        send_fields(OP_READ, REG_IN, 5'd0, '0, 5'd31, 1'b1, 1'b1);
        send_fields(OP_READ, REG_DIR, 5'd0, '0, 5'd0, 1'b0, 1'b0);
        send_fields(OP_READ, REG_CNF, 5'd0, '0, 5'd0, 1'b0, 1'b0);
        send_fields(OP_READ, REG_CNF, 5'd31, '0, 5'd0, 1'b0, 1'b0);
        send_fields(OP_READ, REG_UNMAP_HI, 5'd0, '0, 5'd0, 1'b0, 1'b0);
        // Plain, set and clear writes; DIR fans out into every config word
        send_fields(OP_WRITE, REG_DIR, 5'd0, 32'hFFFF_FFFF, 5'd0, 1'b0, 1'b0);
        send_fields(OP_WRITE, REG_OUT, 5'd0, 32'hA5A5_A5A5, 5'd0, 1'b0, 1'b0);
        send_fields(OP_WRITE, REG_OUTSET, 5'd0, 32'h0F0F_0000, 5'd0, 1'b0, 1'b0);
        send_fields(OP_WRITE, REG_OUTCLR, 5'd0, 32'h0000_FFFF, 5'd0, 1'b0, 1'b0);
        send_fields(OP_WRITE, REG_DIRCLR, 5'd0, 32'hFFFF_0000, 5'd0, 1'b0, 1'b0);
        send_fields(OP_WRITE, REG_DIRSET, 5'd0, 32'h0001_0000, 5'd0, 1'b0, 1'b0);
        // IN is read-only and unmapped writes are rejected, yet pins settle
        send_fields(OP_WRITE, REG_IN, 5'd0, 32'hFFFF_FFFF, 5'd0, 1'b0, 1'b0);
        send_fields(OP_WRITE, REG_UNMAP_LO, 5'd0, 32'hFFFF_FFFF, 5'd0, 1'b0, 1'b0);
        send_fields(OP_READ, REG_OUTSET, 5'd0, '0, 5'd0, 1'b0, 1'b0);
        // Config words: drive modes, pulls, sense; each one echoes into DIR
        send_fields(OP_WRITE, REG_CNF, 5'd31,
                    cfg_word(1'b1, 1'b0, PULL_UP, DRIVE_LOW, SENSE_NONE),
                    5'd0, 1'b0, 1'b0);
        send_fields(OP_WRITE, REG_CNF, 5'd0,
                    cfg_word(1'b0, 1'b0, PULL_DOWN, DRIVE_BOTH, SENSE_HIGH),
                    5'd0, 1'b0, 1'b0);
        send_fields(OP_WRITE, REG_CNF, 5'd1,
                    cfg_word(1'b0, 1'b0, PULL_NONE, DRIVE_HIGH, SENSE_LOW),
                    5'd0, 1'b0, 1'b0);
        send_fields(OP_WRITE, REG_CNF, 5'd2, 32'hFFFF_FFFF, 5'd0, 1'b0, 1'b0);
        send_fields(OP_WRITE, REG_CNF, 5'd3, 32'h0000_0000, 5'd0, 1'b0, 1'b0);
        // Pin events: sense high, sense low, release to the pull, external drive on pin 31
        send_fields(OP_EVENT, REG_OUT, 5'd0, '0, 5'd0, 1'b1, 1'b1);
        send_fields(OP_EVENT, REG_OUT, 5'd0, '0, 5'd1, 1'b1, 1'b0);
        send_fields(OP_EVENT, REG_OUT, 5'd0, '0, 5'd0, 1'b0, 1'b1);
        send_fields(OP_EVENT, REG_OUT, 5'd0, '0, 5'd31, 1'b1, 1'b1);
        send_fields(OP_READ, REG_IN, 5'd0, '0, 5'd0, 1'b0, 1'b0);
        send_fields(OP_IDLE, REG_CNF, 5'd2, 32'hFFFF_FFFF, 5'd31, 1'b1, 1'b1);
        drain();

        // Random part: mostly config writes, pin events and register writes
        // that walk the pins through their modes, with reads, rejected
        // accesses and idle beats mixed in.
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            calm = (n >= 500) && (n < 800);
            if (n > 0 && n % DRAIN_EVERY == 0)
                drain();
            raw = {$urandom, $urandom};
            it = raw[$bits(gpp_item_t)-1:0];
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                it.operation = OP_WRITE;
                it.reg_select = REG_CNF;
                if ($urandom_range(9) != 0)
                    it.write_data = cfg_word(1'($urandom_range(1)),
                                             $urandom_range(3) == 0,
                                             2'($urandom_range(3)),
                                             3'($urandom_range(7)),
                                             2'($urandom_range(3)));
            end
            else if (pick < 50)
            begin
                it.operation = OP_EVENT;
                it.pin_driven = ($urandom_range(3) != 0);
            end
            else if (pick < 65)
            begin
                it.operation = OP_WRITE;
                it.reg_select = 4'($urandom_range(REG_OUT, REG_OUTCLR));
            end
            else if (pick < 75)
            begin
                it.operation = OP_WRITE;
                it.reg_select = 4'($urandom_range(REG_DIR, REG_DIRCLR));
            end
            else if (pick < 90)
                it.operation = OP_READ;
            else if (pick < 95)
            begin
                it.operation = OP_WRITE;
                it.reg_select = $urandom_range(1) ? REG_IN
                                : 4'($urandom_range(REG_UNMAP_LO, REG_UNMAP_HI));
            end
            else
                it.operation = OP_IDLE;
            send_item(it);
        end
        calm = 1'b0;

        // Wait out the last results, then let the pipeline run dry.
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.log_mismatch("results never returned", sb.expected_q.size(), '0);

        $display("covered %0d reads, %0d writes, %0d pin events, %0d idle beats",
                 sb.op_seen[OP_READ], sb.op_seen[OP_WRITE], sb.op_seen[OP_EVENT],
                 sb.op_seen[OP_IDLE]);
        $display("checked %0d result beats, %0d with sense detect raised, %0d mismatches",
                 sb.checked, sb.detect_seen, sb.errors);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/gpp_pkg.sv
hw/rtl/gpp_in_stage.sv
hw/rtl/gpp_pin_eval.sv
hw/rtl/gpio_port_pin_model.sv
tb/tb.sv
